// File: hdl/rbfi_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rbfi_pkg: shared types and constants of the rigid body force integrator
// Holds the word formats, the register indexes, the pipeline geometry and
// the saturation helper used by the integration lanes.
// ----------------------------------------------------------------------------
package rbfi_pkg;

    localparam int FRAC_W     = 16;           // Q16.16 fraction bits
    localparam int CFG_IDX_W  = 3;
    localparam int MUL_W      = 62;           // products clip to 2^62-1
    localparam int FORCE_W    = 47;           // force magnitude clips to 2^47-1
    localparam int DIV_Q_W    = 48;           // quotient bits developed
    localparam int DIV_STEP   = 2;            // quotient bits per stage
    localparam int DIV_STAGES = DIV_Q_W / DIV_STEP;
    localparam int ACC_W      = 49;           // signed acceleration width
    localparam int SQ_W       = 49;
    localparam int S2_W       = 50;
    localparam int PIPE_LAT   = 16 + DIV_STAGES;

    localparam logic [16:0] TIME_STEP_RST = 17'd1092;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRAV_X      = 3'd0,
        CFG_GRAV_Y      = 3'd1,
        CFG_WIND_X      = 3'd2,
        CFG_WIND_Y      = 3'd3,
        CFG_AIR_DENSITY = 3'd4,
        CFG_TIME_STEP   = 3'd5
    } cfg_idx_e;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic [30:0]        body_mass;
        logic [30:0]        body_area;
        logic [30:0]        drag_coef;
        logic [30:0]        lift_coef;
        logic               impulse_valid;
        logic signed [31:0] impulse_x;
        logic signed [31:0] impulse_y;
    } item_t;

    typedef struct packed {
        logic signed [31:0] new_pos_x;
        logic signed [31:0] new_pos_y;
        logic signed [31:0] new_vel_x;
        logic signed [31:0] new_vel_y;
        logic signed [31:0] move_x;
        logic signed [31:0] move_y;
        logic               zero_mass;
        logic               saturated;
    } result_t;

    // Side information carried alongside the divider stages.
    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic               zero_mass;
        logic               fsat;
        logic               neg_x;
        logic               neg_y;
        logic               ovf_x;
        logic               ovf_y;
    } div_side_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic               zero_mass;
        logic               fsat;
    } acc_side_t;

    typedef struct packed {
        logic [FORCE_W-1:0] m;
        logic               neg;
        logic               clip;
    } force_t;

    typedef struct packed {
        logic               sat;
        logic signed [31:0] val;
    } sat32_t;

    // Clamp a wide signed value into the signed 32 bit range.
    function automatic sat32_t sat32(input logic signed [63:0] v);
        sat32_t r;
        if (v > 64'sd2147483647) begin
            r.sat = 1'b1;
            r.val = {1'b0, {31{1'b1}}};
        end
        else if (v < -64'sd2147483648) begin
            r.sat = 1'b1;
            r.val = {1'b1, 31'd0};
        end
        else begin
            r.sat = 1'b0;
            r.val = v[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// File: hdl/rbfi_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rbfi_mul: two stage wide multiply with shift and clip
// The wide operand is split at bit 32 into two parts; the partial products are
// registered, then recombined, shifted by the fraction width and clipped.
// ----------------------------------------------------------------------------
module rbfi_mul
    import rbfi_pkg::*;
#(
    parameter int A_W = 62,
    parameter int B_W = 31
)
(
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic [A_W-1:0]   a,
    input  wire logic [B_W-1:0]   b,
    input  wire logic             sat_in,
    output logic      [MUL_W-1:0] res,
    output logic                  sat_out
);

    localparam int HI_W = A_W - 32;
    localparam int PL_W = 32 + B_W;
    localparam int PH_W = HI_W + B_W;
    localparam int P_W  = A_W + B_W;
    localparam int SH_W = P_W - FRAC_W;

    logic [PL_W-1:0]  pl_next, pl_reg;
    logic [PH_W-1:0]  ph_next, ph_reg;
    logic             sat1_reg;
    logic [P_W-1:0]   prod;
    logic [SH_W-1:0]  shifted;
    logic             clip;
    logic [MUL_W-1:0] res_next, res_reg;
    logic             sat2_next, sat2_reg;

    assign pl_next = PL_W'(a[31:0]) * PL_W'(b);
    assign ph_next = PH_W'(a[A_W-1:32]) * PH_W'(b);

    always_comb
    begin
        prod      = {ph_reg, 32'd0} + P_W'(pl_reg);
        shifted   = prod[P_W-1:FRAC_W];
        clip      = |shifted[SH_W-1:MUL_W];
        res_next  = clip ? {MUL_W{1'b1}} : shifted[MUL_W-1:0];
        sat2_next = sat1_reg | clip;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pl_reg   <= pl_next;
            ph_reg   <= ph_next;
            sat1_reg <= sat_in;
            res_reg  <= res_next;
            sat2_reg <= sat2_next;
        end
    end

    assign res     = res_reg;
    assign sat_out = sat2_reg;

endmodule
`default_nettype wire

// File: hdl/rbfi_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rbfi_div: pipelined restoring divider
// Develops the quotient a fixed number of bits per stage; the divisor
// travels with each partial remainder.
// ----------------------------------------------------------------------------
module rbfi_div
    import rbfi_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               en,
    input  wire logic [30:0]        divisor,
    input  wire logic [30:0]        rem_in,
    input  wire logic [DIV_Q_W-1:0] dq_in,
    output logic      [DIV_Q_W-1:0] quot
);

    logic [30:0]        rem_reg  [DIV_STAGES];
    logic [DIV_Q_W-1:0] dq_reg   [DIV_STAGES];
    logic [30:0]        dv_reg   [DIV_STAGES];
    logic [30:0]        rem_next [DIV_STAGES];
    logic [DIV_Q_W-1:0] dq_next  [DIV_STAGES];
    logic [30:0]        dv_next  [DIV_STAGES];

    always_comb
    begin
        logic [30:0]        r;
        logic [DIV_Q_W-1:0] d;
        logic [30:0]        v;
        logic [31:0]        t;
        logic               ge;
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            if (s == 0)
            begin
                r = rem_in;
                d = dq_in;
                v = divisor;
            end
            else
            begin
                r = rem_reg[s-1];
                d = dq_reg[s-1];
                v = dv_reg[s-1];
            end
            for (int i = 0; i < DIV_STEP; i++)
            begin
                t  = {r, d[DIV_Q_W-1]};
                ge = (t >= {1'b0, v});
                r  = ge ? 31'(t - {1'b0, v}) : t[30:0];
                d  = {d[DIV_Q_W-2:0], ge};
            end
            rem_next[s] = r;
            dq_next[s]  = d;
            dv_next[s]  = v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < DIV_STAGES; s++)
            begin
                rem_reg[s] <= rem_next[s];
                dq_reg[s]  <= dq_next[s];
                dv_reg[s]  <= dv_next[s];
            end
        end
    end

    assign quot = dq_reg[DIV_STAGES-1];

endmodule
`default_nettype wire

// File: hdl/rbfi_integ.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rbfi_integ: four stage Verlet update for one axis
// Scales acceleration and velocity by the time step, forms the move and
// the new velocity, then the new position, clamping each to 32 bits.
// ----------------------------------------------------------------------------
module rbfi_integ
    import rbfi_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    en,
    input  wire logic signed [ACC_W-1:0] acc,
    input  wire logic signed [31:0]      pos,
    input  wire logic signed [31:0]      vel,
    input  wire logic [16:0]             dt,
    output logic signed [31:0]           new_pos,
    output logic signed [31:0]           new_vel,
    output logic signed [31:0]           move,
    output logic                         sat
);

    logic [ACC_W-1:0]   am_full;
    logic [64:0]        adt_full;
    logic [32:0]        vm;
    logic [49:0]        vdt_full;
    logic [48:0]        adt1_reg;
    logic [33:0]        vdt1_reg;
    logic               nega1_reg, negv1_reg;
    logic signed [31:0] pos1_reg, vel1_reg;

    logic [65:0]        adt2_full;
    logic [48:0]        adt2m;
    logic signed [49:0] adt2s_next, adt2s_reg;
    logic signed [34:0] vdts_next, vdts_reg;
    logic signed [50:0] vn_next, vn_reg;
    logic signed [31:0] pos2_reg;

    sat32_t             mv, vv, pp;
    logic signed [31:0] move3_reg, vel3_reg, pos3_reg;
    logic               sat3_reg;
    logic signed [31:0] pos4_reg, vel4_reg, move4_reg;
    logic               sat4_reg;

    always_comb
    begin
        am_full  = acc[ACC_W-1] ? -acc : acc;
        adt_full = {17'd0, am_full[ACC_W-2:0]} * {48'd0, dt};
        vm       = vel[31] ? -{vel[31], vel} : {vel[31], vel};
        vdt_full = {17'd0, vm} * {33'd0, dt};
    end

    always_comb
    begin
        adt2_full  = {17'd0, adt1_reg} * {49'd0, dt};
        adt2m      = adt2_full[65:17];
        adt2s_next = nega1_reg ? -$signed({1'b0, adt2m}) : $signed({1'b0, adt2m});
        vdts_next  = negv1_reg ? -$signed({1'b0, vdt1_reg}) : $signed({1'b0, vdt1_reg});
        vn_next    = 51'(vel1_reg) +
                     (nega1_reg ? -$signed({2'b0, adt1_reg}) : $signed({2'b0, adt1_reg}));
    end

    always_comb
    begin
        mv = sat32(64'(vdts_reg) + 64'(adt2s_reg));
        vv = sat32(64'(vn_reg));
        pp = sat32(64'(pos3_reg) + 64'(move3_reg));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            adt1_reg   <= adt_full[64:16];
            vdt1_reg   <= vdt_full[49:16];
            nega1_reg  <= acc[ACC_W-1];
            negv1_reg  <= vel[31];
            pos1_reg   <= pos;
            vel1_reg   <= vel;

            adt2s_reg  <= adt2s_next;
            vdts_reg   <= vdts_next;
            vn_reg     <= vn_next;
            pos2_reg   <= pos1_reg;

            move3_reg  <= mv.val;
            vel3_reg   <= vv.val;
            sat3_reg   <= mv.sat | vv.sat;
            pos3_reg   <= pos2_reg;

            pos4_reg   <= pp.val;
            move4_reg  <= move3_reg;
            vel4_reg   <= vel3_reg;
            sat4_reg   <= sat3_reg | pp.sat;
        end
    end

    assign new_pos = pos4_reg;
    assign new_vel = vel4_reg;
    assign move    = move4_reg;
    assign sat     = sat4_reg;

endmodule
`default_nettype wire

// File: hdl/rigid_body_force_integrator_unit.sv
// Throughput: one word per cycle while the output buffer has room; the
// 24 stage restoring divider (two quotient bits per stage) sets most of the
// pipeline depth.
// Reset: rst_n is asynchronous and active low; it empties the pipeline and the
// two entry output buffer and loads the register defaults (time_step 1092).
`default_nettype none
// ----------------------------------------------------------------------------
// rigid_body_force_integrator_unit: streaming 2D velocity Verlet step
// Computes aerodynamic drag and lift, adds the impulse, divides by mass,
// adds gravity and advances one body per word through a deep pipeline.
// ----------------------------------------------------------------------------
module rigid_body_force_integrator_unit
    import rbfi_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 item_valid,
    output logic                      item_stall,
    input  wire item_t                item,
    output logic                      result_valid,
    input  wire logic                 result_stall,
    output result_t                   result,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]          cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers. They are to be written only while the pipeline
    // is empty, a rule on the user that the block has no check for, so every stage reads them directly.
    // ------------------------------------------------------------------
    logic signed [31:0] grav_x_reg, grav_y_reg, wind_x_reg, wind_y_reg;
    logic [30:0]        air_density_reg;
    logic [16:0]        time_step_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grav_x_reg      <= '0;
            grav_y_reg      <= '0;
            wind_x_reg      <= '0;
            wind_y_reg      <= '0;
            air_density_reg <= '0;
            time_step_reg   <= TIME_STEP_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_idx_e'(cfg_index))
                CFG_GRAV_X:      grav_x_reg      <= cfg_data;
                CFG_GRAV_Y:      grav_y_reg      <= cfg_data;
                CFG_WIND_X:      wind_x_reg      <= cfg_data;
                CFG_WIND_Y:      wind_y_reg      <= cfg_data;
                CFG_AIR_DENSITY: air_density_reg <= cfg_data[30:0];
                CFG_TIME_STEP:   time_step_reg   <= cfg_data[16:0];
                default:         ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control. The whole pipeline advances together; it halts
    // only when the output buffer holds two words, so item_stall comes
    // from a register and never from result_stall directly.
    // ------------------------------------------------------------------
    logic                en;
    logic [PIPE_LAT:1]   vld_reg;
    logic [1:0]          count_reg;
    logic                wr_ptr_reg, rd_ptr_reg;
    result_t             buf_reg [2];
    result_t             res_pipe;
    logic                push, pop;

    assign en         = (count_reg != 2'd2);
    assign item_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[PIPE_LAT-1:1], item_valid};
    end

    // Input word and its copies for the aerodynamic stages (stages 1 to 10).
    item_t it_reg [1:10];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            it_reg[1] <= item;
            for (int k = 2; k <= 10; k++)
                it_reg[k] <= it_reg[k-1];
        end
    end

    // Stage 2: magnitude of the velocity relative to the wind.
    logic signed [32:0] relx, rely;
    logic [32:0]        rx_next, ry_next, rx_reg, ry_reg;

    always_comb
    begin
        relx    = $signed({it_reg[1].vel_x[31], it_reg[1].vel_x}) -
                  $signed({wind_x_reg[31], wind_x_reg});
        rely    = $signed({it_reg[1].vel_y[31], it_reg[1].vel_y}) -
                  $signed({wind_y_reg[31], wind_y_reg});
        rx_next = relx[32] ? -relx : relx;
        ry_next = rely[32] ? -rely : rely;
    end

    // Stage 3: squares; stage 4: squared speed.
    logic [65:0]     sqx_full, sqy_full;
    logic [SQ_W-1:0] sqx_reg, sqy_reg;
    logic [S2_W-1:0] s2_reg;

    always_comb
    begin
        sqx_full = {33'd0, rx_reg} * {33'd0, rx_reg};
        sqy_full = {33'd0, ry_reg} * {33'd0, ry_reg};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rx_reg  <= rx_next;
            ry_reg  <= ry_next;
            sqx_reg <= sqx_full[64:16];
            sqy_reg <= sqy_full[64:16];
            s2_reg  <= {1'b0, sqx_reg} + {1'b0, sqy_reg};
        end
    end

    // Stages 5 to 10: dynamic pressure times area, then drag and lift.
    logic [MUL_W-1:0] dens_res, q_res, drag_res, lift_res;
    logic             dens_sat, q_sat, drag_sat, lift_sat;

    rbfi_mul #(.A_W(S2_W), .B_W(31)) u_mul_dens
    (
        .clk     (clk),
        .en      (en),
        .a       (s2_reg),
        .b       (air_density_reg),
        .sat_in  (1'b0),
        .res     (dens_res),
        .sat_out (dens_sat)
    );

    rbfi_mul #(.A_W(MUL_W), .B_W(31)) u_mul_area
    (
        .clk     (clk),
        .en      (en),
        .a       (dens_res),
        .b       (it_reg[6].body_area),
        .sat_in  (dens_sat),
        .res     (q_res),
        .sat_out (q_sat)
    );

    rbfi_mul #(.A_W(MUL_W), .B_W(31)) u_mul_drag
    (
        .clk     (clk),
        .en      (en),
        .a       (q_res),
        .b       (it_reg[8].drag_coef),
        .sat_in  (q_sat),
        .res     (drag_res),
        .sat_out (drag_sat)
    );

    rbfi_mul #(.A_W(MUL_W), .B_W(31)) u_mul_lift
    (
        .clk     (clk),
        .en      (en),
        .a       (q_res),
        .b       (it_reg[8].lift_coef),
        .sat_in  (1'b0),
        .res     (lift_res),
        .sat_out (lift_sat)
    );

    // Stage 11: signed forces. Drag opposes a non-negative wind along x,
    // lift follows the sign of the wind along y; the impulse is added and
    // the magnitude is clipped before the divide.
    function automatic force_t force_axis(input logic [MUL_W-2:0] aero,
                                          input logic aero_neg,
                                          input logic imp_en,
                                          input logic signed [31:0] imp);
        logic signed [63:0] f;
        logic [63:0]        fm;
        force_t             r;
        f = aero_neg ? -$signed({3'b0, aero}) : $signed({3'b0, aero});
        if (imp_en)
            f = f + 64'(imp);
        fm     = f[63] ? -f : f;
        r.neg  = f[63];
        r.clip = (fm[63:FORCE_W] != '0);
        r.m    = r.clip ? {FORCE_W{1'b1}} : fm[FORCE_W-1:0];
        return r;
    endfunction

    force_t             fx, fy;
    div_side_t          side11_next, side11_reg;
    logic [FORCE_W-1:0] mx_reg, my_reg;
    logic [30:0]        mass11_reg;

    always_comb
    begin
        fx = force_axis(drag_res[MUL_W-1:1], !wind_x_reg[31],
                        it_reg[10].impulse_valid, it_reg[10].impulse_x);
        fy = force_axis(lift_res[MUL_W-1:1], wind_y_reg[31],
                        it_reg[10].impulse_valid, it_reg[10].impulse_y);
        side11_next.pos_x     = it_reg[10].pos_x;
        side11_next.pos_y     = it_reg[10].pos_y;
        side11_next.vel_x     = it_reg[10].vel_x;
        side11_next.vel_y     = it_reg[10].vel_y;
        side11_next.zero_mass = (it_reg[10].body_mass == '0);
        side11_next.fsat      = drag_sat | lift_sat | fx.clip | fy.clip;
        side11_next.neg_x     = fx.neg;
        side11_next.neg_y     = fy.neg;
        // The quotient reaches 2^47 exactly when the top force bits reach
        // the mass; the divider then only needs the lower 48 quotient bits.
        side11_next.ovf_x     = ({15'd0, fx.m[FORCE_W-1:31]} >= it_reg[10].body_mass);
        side11_next.ovf_y     = ({15'd0, fy.m[FORCE_W-1:31]} >= it_reg[10].body_mass);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side11_reg <= side11_next;
            mx_reg     <= fx.m;
            my_reg     <= fy.m;
            mass11_reg <= it_reg[10].body_mass;
        end
    end

    // Stages 12 to 35: (|F| << 16) / mass on both axes.
    logic [DIV_Q_W-1:0] quot_x, quot_y;
    div_side_t          dside_reg [DIV_STAGES];

    rbfi_div u_div_x
    (
        .clk     (clk),
        .en      (en),
        .divisor (mass11_reg),
        .rem_in  ({16'd0, mx_reg[FORCE_W-1:32]}),
        .dq_in   ({mx_reg[31:0], 16'd0}),
        .quot    (quot_x)
    );

    rbfi_div u_div_y
    (
        .clk     (clk),
        .en      (en),
        .divisor (mass11_reg),
        .rem_in  ({16'd0, my_reg[FORCE_W-1:32]}),
        .dq_in   ({my_reg[31:0], 16'd0}),
        .quot    (quot_y)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dside_reg[0] <= side11_reg;
            for (int s = 1; s < DIV_STAGES; s++)
                dside_reg[s] <= dside_reg[s-1];
        end
    end

    // Stage 36: acceleration = gravity + signed quotient; zero mass forces
    // zero on both axes and hides any clipping in the force path.
    function automatic logic signed [ACC_W-1:0] accel_axis(
        input logic signed [31:0] grav,
        input logic [DIV_Q_W-2:0] q,
        input logic               neg,
        input logic               zero);
        logic signed [ACC_W-1:0] qs;
        logic signed [ACC_W-1:0] a;
        qs = $signed({2'b0, q});
        a  = ACC_W'(grav) + (neg ? -qs : qs);
        return zero ? '0 : a;
    endfunction

    div_side_t               dl;
    logic [DIV_Q_W-2:0]      qx, qy;
    logic signed [ACC_W-1:0] ax_reg, ay_reg;
    acc_side_t               aside_next, aside_reg;

    always_comb
    begin
        dl = dside_reg[DIV_STAGES-1];
        qx = dl.ovf_x ? {(DIV_Q_W-1){1'b1}} : quot_x[DIV_Q_W-2:0];
        qy = dl.ovf_y ? {(DIV_Q_W-1){1'b1}} : quot_y[DIV_Q_W-2:0];
        aside_next.pos_x     = dl.pos_x;
        aside_next.pos_y     = dl.pos_y;
        aside_next.vel_x     = dl.vel_x;
        aside_next.vel_y     = dl.vel_y;
        aside_next.zero_mass = dl.zero_mass;
        aside_next.fsat      = !dl.zero_mass & (dl.fsat | dl.ovf_x | dl.ovf_y);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax_reg    <= accel_axis(grav_x_reg, qx, dl.neg_x, dl.zero_mass);
            ay_reg    <= accel_axis(grav_y_reg, qy, dl.neg_y, dl.zero_mass);
            aside_reg <= aside_next;
        end
    end

    // Stages 37 to 40: integration per axis.
    logic signed [31:0] npx, npy, nvx, nvy, mvx, mvy;
    logic               satx, saty;
    logic [3:0]         zm_pipe_reg, fs_pipe_reg;

    rbfi_integ u_integ_x
    (
        .clk     (clk),
        .en      (en),
        .acc     (ax_reg),
        .pos     (aside_reg.pos_x),
        .vel     (aside_reg.vel_x),
        .dt      (time_step_reg),
        .new_pos (npx),
        .new_vel (nvx),
        .move    (mvx),
        .sat     (satx)
    );

    rbfi_integ u_integ_y
    (
        .clk     (clk),
        .en      (en),
        .acc     (ay_reg),
        .pos     (aside_reg.pos_y),
        .vel     (aside_reg.vel_y),
        .dt      (time_step_reg),
        .new_pos (npy),
        .new_vel (nvy),
        .move    (mvy),
        .sat     (saty)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zm_pipe_reg <= {zm_pipe_reg[2:0], aside_reg.zero_mass};
            fs_pipe_reg <= {fs_pipe_reg[2:0], aside_reg.fsat};
        end
    end

    always_comb
    begin
        res_pipe.new_pos_x = npx;
        res_pipe.new_pos_y = npy;
        res_pipe.new_vel_x = nvx;
        res_pipe.new_vel_y = nvy;
        res_pipe.move_x    = mvx;
        res_pipe.move_y    = mvy;
        res_pipe.zero_mass = zm_pipe_reg[3];
        res_pipe.saturated = fs_pipe_reg[3] | satx | saty;
    end

    // ------------------------------------------------------------------
    // Two entry output buffer. A word leaving the last stage is pushed
    // whenever the pipeline advances; there is always room then.
    // ------------------------------------------------------------------
    assign push         = en & vld_reg[PIPE_LAT];
    assign pop          = result_valid & !result_stall;
    assign result_valid = (count_reg != 2'd0);
    assign result       = buf_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            buf_reg[wr_ptr_reg] <= res_pipe;
    end

endmodule
`default_nettype wire

// File: hdl/rbfi_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rbfi_checker: port level checks for the force integrator
// Tracks words in flight and checks the output handshake and the input
// stall behavior seen at the ports.
// ----------------------------------------------------------------------------
module rbfi_checker
    import rbfi_pkg::*;
(
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    item_valid,
    input wire logic    item_stall,
    input wire logic    result_valid,
    input wire logic    result_stall,
    input wire result_t result
);

    localparam int CNT_W = $clog2(PIPE_LAT + 4);

    logic [CNT_W-1:0] outst_reg;
    logic             accept, deliver;

    assign accept  = item_valid & !item_stall;
    assign deliver = result_valid & !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            outst_reg <= '0;
        else if (accept && !deliver)
            outst_reg <= outst_reg + 1'b1;
        else if (deliver && !accept)
            outst_reg <= outst_reg - 1'b1;
    end

    // A stalled result word holds.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result word changed while stalled");

    // The input only stalls while a result word is waiting at the output.
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> result_valid)
        else $error("input stalled with no result pending");

    // Taking a word from a full buffer frees the input once the registered count drops.
    a_stall_release: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall && !result_stall |=> !item_stall)
        else $error("input still stalled after the output drained");

    // No result appears without a word accepted for it.
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> outst_reg != '0)
        else $error("result word without an accepted input word");

endmodule

bind rigid_body_force_integrator_unit rbfi_checker u_rbfi_checker (.*);
`default_nettype wire
